// ----- rtl/fir115_pkg.sv -----
// Shared types and constants for the 115-tap FIR filter.
`default_nettype none

package fir115_pkg;

	localparam int DATA_W = 24;
	localparam int IDX_W  = 7;
	localparam int PROD_W = 2 * DATA_W;
	localparam int Q_FRAC = 23;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_COEF   = 1'b1;

	localparam int OUT_MAX = 8388607;
	localparam int OUT_MIN = -8388608;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} fir_state_t;

	// controls from the sequencer into the multiply-accumulate unit
	typedef struct packed {
		logic clear;    // start of a new sum
		logic issue_s1; // RAM read data valid this cycle
		logic live_s1;  // tap holds a real sample (else counts as zero)
	} mac_ctrl_t;

	typedef struct packed {
		logic busy;     // product still in flight
	} mac_stat_t;

endpackage

`default_nettype wire

// ----- rtl/fir115_ifs.sv -----
// Channel interfaces: sample/coefficient input, filtered output, silence write.
`default_nettype none

interface fir115_in_if import fir115_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     operation;
	logic signed [DATA_W-1:0] sample_in;
	logic        [IDX_W-1:0]  coeff_index;
	logic signed [DATA_W-1:0] coeff_value;

	modport source (output valid, output operation, output sample_in,
		output coeff_index, output coeff_value, input ready);
	modport sink (input valid, input operation, input sample_in,
		input coeff_index, input coeff_value, output ready);
endinterface

interface fir115_out_if import fir115_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] filtered_out;

	modport source (output valid, output filtered_out, input ready);
	modport sink (input valid, input filtered_out, output ready);
endinterface

interface fir115_cfg_if;
	logic valid;
	logic ready;
	logic silence;

	modport source (output valid, output silence, input ready);
	modport sink (input valid, input silence, output ready);
endinterface

`default_nettype wire

// ----- rtl/fir115_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fir115_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 115,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/fir115_mac.sv -----
// Shared multiply-accumulate unit with round-to-nearest and 24-bit saturation.
`default_nettype none

module fir115_mac import fir115_pkg::*; #(
	parameter int TAPS = 115,
	localparam int ACC_W = PROD_W + ((TAPS > 1) ? $clog2(TAPS) : 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mac_ctrl_t                ctrl,
	input  wire logic signed [DATA_W-1:0] tap_d,
	input  wire logic signed [DATA_W-1:0] coef_d,
	output mac_stat_t                     stat,
	output logic signed [DATA_W-1:0]      result
);

	logic signed [PROD_W-1:0] prod_s2;
	logic                     vld_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W:0]    rnd;
	logic signed [ACC_W:0]    quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctrl.issue_s1;
		end
	end

	// unwritten delay slots read as zero until the line has filled once
	always_ff @(posedge clk) begin
		if (ctrl.live_s1) begin
			prod_s2 <= tap_d * coef_d;
		end else begin
			prod_s2 <= '0;
		end
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// floor((acc + half) / 2^23): ties go toward plus infinity
	always_comb begin
		rnd = $signed({acc_q[ACC_W-1], acc_q})
			+ $signed((ACC_W+1)'(1 << (Q_FRAC - 1)));
		quo = rnd >>> Q_FRAC;
		if (quo > $signed((ACC_W+1)'(OUT_MAX))) begin
			result = DATA_W'(OUT_MAX);
		end else if (quo < $signed((ACC_W+1)'(OUT_MIN))) begin
			result = DATA_W'(OUT_MIN);
		end else begin
			result = quo[DATA_W-1:0];
		end
	end

	assign stat.busy = vld_s2;

endmodule

`default_nettype wire

// ----- rtl/fir_filter_115_tap_unit.sv -----
// Top level: direct-form FIR filter with RAM-held delay line and coefficients.
//
//  channel  role    transaction
//  in_ch    sink    operation 0: sample_in -> one result; 1: coeff_index/coeff_value write
//  out_ch   source  filtered_out, Q1.23, rounded and saturated
//  cfg_ch   sink    silence bit (mute output, hold delay line)
//
// A sample passes through the load, tap walk, drain and finish states from accept to
// result, set by the single multiply-accumulate walking every tap through the two RAM read ports.
// A coefficient is written as it is accepted; a muted sample goes straight to the finish
// state and frees in_ch when its zero result is loaded into the output register.
// The delay line is a circular buffer; a fill count makes taps never written since
// reset read as zero, so no clearing pass runs after reset.
// in_ch is held off while a sample is in work; the finished result sits in an output
// register, so the next item is taken while it waits for out_ch.ready.
`default_nettype none

module fir_filter_115_tap_unit import fir115_pkg::*; #(
	parameter int TAPS = 115,
	localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1,
	localparam int CW = $clog2(TAPS + 1)
) (
	input wire logic   clk,
	input wire logic   arst_n,
	fir115_in_if.sink  in_ch,
	fir115_out_if.source out_ch,
	fir115_cfg_if.sink cfg_ch
);

	fir_state_t state_q, state_d;

	logic                     silence_q;
	logic                     zero_q;
	logic signed [DATA_W-1:0] sample_q;
	logic [AW-1:0]            head_q;
	logic [AW-1:0]            rd_ptr_q;
	logic [AW-1:0]            tap_q;
	logic [CW-1:0]            fill_q;
	logic                     iss_s1;
	logic                     live_s1;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_data_q;

	logic in_acc, accept_sample, coef_we, dly_we, issue, clear, out_load, last_tap;
	logic signed [DATA_W-1:0] dly_rdata, coef_rdata, mac_result;
	mac_ctrl_t mac_ctrl;
	mac_stat_t mac_stat;

	assign in_acc        = in_ch.valid && in_ch.ready;
	assign accept_sample = in_acc && (in_ch.operation == OP_SAMPLE);
	assign coef_we       = in_acc && (in_ch.operation == OP_COEF)
		&& (32'(in_ch.coeff_index) < TAPS);
	assign last_tap      = (tap_q == AW'(TAPS - 1));

	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		dly_we      = 1'b0;
		issue       = 1'b0;
		clear       = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (accept_sample) begin
					state_d = silence_q ? ST_FINISH : ST_LOAD;
				end
			end
			ST_LOAD: begin
				dly_we  = 1'b1;
				clear   = 1'b1;
				state_d = ST_RUN;
			end
			ST_RUN: begin
				issue = 1'b1;
				if (last_tap) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!iss_s1 && !mac_stat.busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			silence_q   <= 1'b0;
			head_q      <= '0;
			fill_q      <= '0;
			iss_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			iss_s1  <= issue;
			if (cfg_ch.valid) begin
				silence_q <= cfg_ch.silence;
			end
			if (dly_we) begin
				head_q <= (head_q == AW'(TAPS - 1)) ? '0 : head_q + 1'b1;
				if (fill_q != CW'(TAPS)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// tap k of the newest sample sits k slots behind the write head
	always_ff @(posedge clk) begin
		live_s1 <= 32'(tap_q) < 32'(fill_q);
		if (accept_sample) begin
			sample_q <= in_ch.sample_in;
			zero_q   <= silence_q;
		end
		if (dly_we) begin
			rd_ptr_q <= head_q;
			tap_q    <= '0;
		end else if (issue) begin
			rd_ptr_q <= (rd_ptr_q == '0) ? AW'(TAPS - 1) : rd_ptr_q - 1'b1;
			tap_q    <= last_tap ? tap_q : tap_q + 1'b1;
		end
		if (out_load) begin
			out_data_q <= zero_q ? '0 : mac_result;
		end
	end

	assign cfg_ch.ready        = 1'b1;
	assign out_ch.valid        = out_valid_q;
	assign out_ch.filtered_out = out_data_q;

	fir115_ram #(.WIDTH(DATA_W), .DEPTH(TAPS)) u_dly_ram (
		.clk   (clk),
		.we    (dly_we),
		.waddr (head_q),
		.wdata (sample_q),
		.raddr (rd_ptr_q),
		.rdata (dly_rdata)
	);

	fir115_ram #(.WIDTH(DATA_W), .DEPTH(TAPS)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (AW'(in_ch.coeff_index)),
		.wdata (in_ch.coeff_value),
		.raddr (tap_q),
		.rdata (coef_rdata)
	);

	assign mac_ctrl.clear    = clear;
	assign mac_ctrl.issue_s1 = iss_s1;
	assign mac_ctrl.live_s1  = live_s1;

	fir115_mac #(.TAPS(TAPS)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.tap_d  (dly_rdata),
		.coef_d (coef_rdata),
		.stat   (mac_stat),
		.result (mac_result)
	);

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && last_tap) |=> (state_q == ST_DRAIN))
		else $error("tap walk did not end after the last tap");

	a_no_write_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		dly_we |-> (!iss_s1 && !mac_stat.busy))
		else $error("delay line written while reads are in flight");

	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (!iss_s1 && !mac_stat.busy))
		else $error("result taken before the sum was complete");

	a_result_posted: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("finished result not posted");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= TAPS)
		else $error("fill count past tap count");

endmodule

`default_nettype wire
